[rtl/oaht_pkg.sv]
// package for the open-addressing hash table
// types, constants and codes shared by controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int MOD_W = ADDR_W + 1;
   localparam int KEY_W = 31;
   localparam int CNT_W = 32;
   localparam int DIV_BITS = 4;
   localparam int DIV_STEPS = (KEY_W + DIV_BITS) / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(4093);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic CSR_PROBE_MODE = 1'b0;
   localparam logic CSR_TABLE_MODULUS = 1'b1;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_QUADRATIC = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FOUND = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_LIMIT = 2'd3;

   typedef struct packed {
      logic func;
      logic [KEY_W-1:0] lookup_key;
      logic clear_after;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [11:0] slot_index;
      logic [12:0] probe_count;
      logic [31:0] collision_total;
   } rsp_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_step;
      logic rd;
      logic adv;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic probe_end;
   } sts_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_READ,
      S_CHECK
   } state_type;
endpackage
`default_nettype wire

[rtl/oaht_ctrl.sv]
// controller state machine of the hash table
// depends on oaht_pkg; drives the datapath by cmd_type, reads sts_type
`timescale 1ns / 1ps
`default_nettype none
module oaht_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   output oaht_pkg::cmd_type cmd,
   input  wire oaht_pkg::sts_type sts
);
   import oaht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.probe_end) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.adv = 1'b1;
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

[rtl/oaht_dp.sv]
// datapath of the hash table: slot memory, modulo unit, probe stepping, counter
// depends on oaht_pkg; commanded by oaht_ctrl
`timescale 1ns / 1ps
`default_nettype none
module oaht_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire oaht_pkg::cmd_type cmd,
   output oaht_pkg::sts_type sts,
   input  wire oaht_pkg::req_type req_data,
   input  wire logic csr_we,
   input  wire logic csr_index,
   input  wire logic [12:0] csr_wdata,
   output logic rsp_strobe,
   output oaht_pkg::rsp_type rsp_data
);
   import oaht_pkg::*;

   logic mode_ff;
   logic [MOD_W-1:0] modulus_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic func_ff;
   logic clear_ff;
   logic [KEY_W-1:0] key_ff;
   logic [MOD_W-1:0] m_ff;
   logic [DIV_BITS*DIV_STEPS-1:0] div_sh_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [ADDR_W-1:0] slot_ff;
   logic [MOD_W-1:0] step_ff;
   logic [MOD_W-1:0] n_ff;
   logic [CNT_W-1:0] count_ff;
   logic [KEY_W:0] mem_q_ff;
   logic rsp_strobe_ff;
   rsp_type rsp_ff;
   logic [KEY_W:0] mem [TABLE_DEPTH];

   logic [MOD_W-1:0] eff_mod;
   logic empty, match, limit;
   logic [MOD_W-1:0] slot_sum, slot_next, step_sum, step_next;
   logic mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [KEY_W:0] mem_wd;

   always_comb begin
      eff_mod = modulus_ff;
      if (modulus_ff == '0) begin
         eff_mod = MOD_W'(1);
      end else if (modulus_ff > MOD_W'(TABLE_DEPTH)) begin
         eff_mod = MOD_W'(TABLE_DEPTH);
      end
   end

   // restoring remainder, several dividend bits per cycle
   always_comb begin
      logic [MOD_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[MOD_W-2:0], div_sh_ff[DIV_BITS*DIV_STEPS-1-i]};
         if (r >= m_ff) begin
            r = r - m_ff;
         end
      end
      rem_in = r;
   end

   always_comb begin
      empty = !mem_q_ff[KEY_W];
      match = (func_ff == FUNC_SEARCH) && mem_q_ff[KEY_W] && (mem_q_ff[KEY_W-1:0] == key_ff);
      limit = (n_ff >= m_ff);
      slot_sum = {1'b0, slot_ff} + step_ff;
      slot_next = (slot_sum >= m_ff) ? slot_sum - m_ff : slot_sum;
      step_sum = step_ff + MOD_W'(2);
      if (m_ff == MOD_W'(1)) begin
         step_next = '0;
      end else if (step_sum >= m_ff) begin
         step_next = step_sum - m_ff;
      end else begin
         step_next = step_sum;
      end
      sts.clr_last = (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1));
      sts.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      sts.probe_end = empty || match || limit;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_addr_ff;
      mem_wd = '0;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else if (cmd.finish && empty && (func_ff == FUNC_INSERT)) begin
         mem_we = 1'b1;
         mem_wa = slot_ff;
         mem_wd = {1'b1, key_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd) begin
         mem_q_ff <= mem[slot_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
         modulus_ff <= MODULUS_RESET;
         clr_addr_ff <= '0;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PROBE_MODE) begin
               mode_ff <= csr_wdata[0];
            end else begin
               modulus_ff <= csr_wdata;
            end
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (cmd.adv && (count_ff != '1)) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.finish && clear_ff) begin
            count_ff <= '0;
         end
         rsp_strobe_ff <= cmd.finish;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         clear_ff <= req_data.clear_after;
         key_ff <= req_data.lookup_key;
         m_ff <= eff_mod;
         div_sh_ff <= (DIV_BITS*DIV_STEPS)'(req_data.lookup_key);
         div_cnt_ff <= '0;
         rem_ff <= '0;
         n_ff <= '0;
         step_ff <= (eff_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
      end
      if (cmd.div_step) begin
         div_sh_ff <= div_sh_ff << DIV_BITS;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         rem_ff <= rem_in;
         slot_ff <= rem_in[ADDR_W-1:0];
      end
      if (cmd.adv) begin
         n_ff <= n_ff + MOD_W'(1);
         slot_ff <= slot_next[ADDR_W-1:0];
         if (mode_ff != MODE_LINEAR) begin
            step_ff <= step_next;
         end
      end
      if (cmd.finish) begin
         rsp_ff.probe_count <= n_ff;
         rsp_ff.collision_total <= count_ff;
         if (empty) begin
            if (func_ff == FUNC_INSERT) begin
               rsp_ff.status <= ST_INSERTED;
               rsp_ff.slot_index <= slot_ff;
            end else begin
               rsp_ff.status <= ST_MISSING;
               rsp_ff.slot_index <= '0;
            end
         end else if (match) begin
            rsp_ff.status <= ST_FOUND;
            rsp_ff.slot_index <= slot_ff;
         end else begin
            rsp_ff.status <= ST_LIMIT;
            rsp_ff.slot_index <= '0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

[rtl/open_addressing_hash_table_top.sv]
// top level of the open-addressing hash table
// depends on oaht_pkg, oaht_ctrl and oaht_dp
//
// usage:
//   an item (insert or search of one key) is taken at a clock edge with start
//   high and busy low. its result appears on rsp_data and rsp_strobe is high
//   for exactly one cycle; the receiver cannot hold it off.
//   csr_we writes probe_mode (index 0) or table_modulus (index 1) at once;
//   write only while busy is low.
// remainder and probing:
//   the home slot is found by the remainder unit (4 key bits a cycle), then
//   each probe is a registered read of the slot memory followed by its
//   check. busy drops with the strobe, so the next item may follow in
//   that cycle. one item is worked on at a time.
// reset:
//   synchronous reset restores the control registers and empties the counter,
//   then a clearing pass writes all 4096 slots, one a cycle, with busy held high.
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire oaht_pkg::req_type req_data,
   output logic rsp_strobe,
   output oaht_pkg::rsp_type rsp_data,
   input  wire logic csr_we,
   input  wire logic csr_index,
   input  wire logic [12:0] csr_wdata
);
   import oaht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   oaht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   oaht_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire
